FILE: design/u8cp_pkg.sv
// Package for the UTF-8 to code page 437 transcoder.
// Holds the word types, register map constants and the glyph lookup function.
// No dependencies.
package u8cp_pkg;

    localparam int MAX_SEQ_BYTES = 6;
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam int CAP_W         = 16;
    localparam int ACCUM_W       = 31;
    localparam int LEAD_W        = 4;

    localparam logic [7:0]       UNDERSCORE   = 8'h5F;
    localparam logic [7:0]       ASCII_LIMIT  = 8'h80;
    localparam logic [CAP_W-1:0] CAP_RESET    = 16'hFFFF;
    localparam logic [CAP_W-1:0] COUNT_MAX    = 16'hFFFF;

    // register index, taken from paddr[2]
    localparam logic REG_DEST_CAPACITY = 1'b0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       done_res;
        logic       unconvertable;
        logic       was_longer;
        logic       utf8_error;
    } out_word_t;

    typedef struct packed {
        logic       found;
        logic [7:0] code;
    } glyph_hit_t;

    // Lowest code page index whose glyph equals the scalar.
    function automatic glyph_hit_t glyph_lookup(input logic [ACCUM_W-1:0] scalar);
        glyph_hit_t hit;
        hit.found = 1'b1;
        hit.code  = UNDERSCORE;
        if (scalar[ACCUM_W-1:16] != '0) begin
            hit.found = 1'b0;
        end else if (scalar[15:7] == '0 && (scalar[6:5] != 2'b00 || scalar[4:0] == 5'd0)) begin
            hit.code = scalar[7:0];
        end else begin
            unique case (scalar[15:0])
                16'h263A: hit.code = 8'h01;  16'h263B: hit.code = 8'h02;
                16'h2665: hit.code = 8'h03;  16'h2666: hit.code = 8'h04;
                16'h2663: hit.code = 8'h05;  16'h2660: hit.code = 8'h06;
                16'h2022: hit.code = 8'h07;  16'h25D8: hit.code = 8'h08;
                16'h25E6: hit.code = 8'h09;  16'h25D9: hit.code = 8'h0A;
                16'h2642: hit.code = 8'h0B;  16'h2640: hit.code = 8'h0C;
                16'h266A: hit.code = 8'h0D;  16'h266B: hit.code = 8'h0E;
                16'h263C: hit.code = 8'h0F;  16'h25B6: hit.code = 8'h10;
                16'h25C0: hit.code = 8'h11;  16'h2195: hit.code = 8'h12;
                16'h203C: hit.code = 8'h13;  16'h00B6: hit.code = 8'h14;
                16'h00A7: hit.code = 8'h15;  16'h25AC: hit.code = 8'h16;
                16'h21A8: hit.code = 8'h17;  16'h2191: hit.code = 8'h18;
                16'h2193: hit.code = 8'h19;  16'h2192: hit.code = 8'h1A;
                16'h2190: hit.code = 8'h1B;  16'h2310: hit.code = 8'h1C;
                16'h2194: hit.code = 8'h1D;  16'h25B2: hit.code = 8'h1E;
                16'h25BC: hit.code = 8'h1F;
                16'h00C7: hit.code = 8'h80;  16'h00FC: hit.code = 8'h81;
                16'h00E9: hit.code = 8'h82;  16'h00E2: hit.code = 8'h83;
                16'h00E4: hit.code = 8'h84;  16'h00E0: hit.code = 8'h85;
                16'h00E5: hit.code = 8'h86;  16'h00E7: hit.code = 8'h87;
                16'h00EA: hit.code = 8'h88;  16'h00EB: hit.code = 8'h89;
                16'h00E8: hit.code = 8'h8A;  16'h00EF: hit.code = 8'h8B;
                16'h00EE: hit.code = 8'h8C;  16'h00EC: hit.code = 8'h8D;
                16'h00C4: hit.code = 8'h8E;  16'h00C5: hit.code = 8'h8F;
                16'h00C9: hit.code = 8'h90;  16'h00E6: hit.code = 8'h91;
                16'h00C6: hit.code = 8'h92;  16'h00F4: hit.code = 8'h93;
                16'h00F6: hit.code = 8'h94;  16'h00F2: hit.code = 8'h95;
                16'h00FB: hit.code = 8'h96;  16'h00F9: hit.code = 8'h97;
                16'h00FF: hit.code = 8'h98;  16'h00D6: hit.code = 8'h99;
                16'h00DC: hit.code = 8'h9A;  16'h00A2: hit.code = 8'h9B;
                16'h00A3: hit.code = 8'h9C;  16'h00A5: hit.code = 8'h9D;
                16'h20A7: hit.code = 8'h9E;  16'h0192: hit.code = 8'h9F;
                16'h00E1: hit.code = 8'hA0;  16'h00ED: hit.code = 8'hA1;
                16'h00F3: hit.code = 8'hA2;  16'h00FA: hit.code = 8'hA3;
                16'h00F1: hit.code = 8'hA4;  16'h00D1: hit.code = 8'hA5;
                16'h00AA: hit.code = 8'hA6;  16'h00BA: hit.code = 8'hA7;
                16'h00BF: hit.code = 8'hA8;  16'h00AC: hit.code = 8'hAA;
                16'h00BD: hit.code = 8'hAB;  16'h00BC: hit.code = 8'hAC;
                16'h00A1: hit.code = 8'hAD;  16'h00AB: hit.code = 8'hAE;
                16'h00BB: hit.code = 8'hAF;
                16'h2591: hit.code = 8'hB0;  16'h2592: hit.code = 8'hB1;
                16'h2593: hit.code = 8'hB2;  16'h2502: hit.code = 8'hB3;
                16'h2524: hit.code = 8'hB4;  16'h2561: hit.code = 8'hB5;
                16'h2562: hit.code = 8'hB6;  16'h2556: hit.code = 8'hB7;
                16'h2555: hit.code = 8'hB8;  16'h2563: hit.code = 8'hB9;
                16'h2551: hit.code = 8'hBA;  16'h2557: hit.code = 8'hBB;
                16'h255D: hit.code = 8'hBC;  16'h255C: hit.code = 8'hBD;
                16'h255B: hit.code = 8'hBE;  16'h2510: hit.code = 8'hBF;
                16'h2514: hit.code = 8'hC0;  16'h2534: hit.code = 8'hC1;
                16'h252C: hit.code = 8'hC2;  16'h251C: hit.code = 8'hC3;
                16'h2500: hit.code = 8'hC4;  16'h253C: hit.code = 8'hC5;
                16'h255E: hit.code = 8'hC6;  16'h255F: hit.code = 8'hC7;
                16'h255A: hit.code = 8'hC8;  16'h2554: hit.code = 8'hC9;
                16'h2569: hit.code = 8'hCA;  16'h2566: hit.code = 8'hCB;
                16'h2560: hit.code = 8'hCC;  16'h2550: hit.code = 8'hCD;
                16'h256C: hit.code = 8'hCE;  16'h2567: hit.code = 8'hCF;
                16'h2568: hit.code = 8'hD0;  16'h2564: hit.code = 8'hD1;
                16'h2565: hit.code = 8'hD2;  16'h2559: hit.code = 8'hD3;
                16'h2558: hit.code = 8'hD4;  16'h2552: hit.code = 8'hD5;
                16'h2553: hit.code = 8'hD6;  16'h256B: hit.code = 8'hD7;
                16'h256A: hit.code = 8'hD8;  16'h2518: hit.code = 8'hD9;
                16'h250C: hit.code = 8'hDA;  16'h2588: hit.code = 8'hDB;
                16'h2584: hit.code = 8'hDC;  16'h258C: hit.code = 8'hDD;
                16'h2590: hit.code = 8'hDE;  16'h2580: hit.code = 8'hDF;
                16'h03B1: hit.code = 8'hE0;  16'h03B2: hit.code = 8'hE1;
                16'h0393: hit.code = 8'hE2;  16'h03C0: hit.code = 8'hE3;
                16'h03A3: hit.code = 8'hE4;  16'h03C3: hit.code = 8'hE5;
                16'h03BC: hit.code = 8'hE6;  16'h03C4: hit.code = 8'hE7;
                16'h03A6: hit.code = 8'hE8;  16'h0398: hit.code = 8'hE9;
                16'h03A9: hit.code = 8'hEA;  16'h03B4: hit.code = 8'hEB;
                16'h221E: hit.code = 8'hEC;  16'h2205: hit.code = 8'hED;
                16'h2208: hit.code = 8'hEE;  16'h2229: hit.code = 8'hEF;
                16'h2261: hit.code = 8'hF0;  16'h00B1: hit.code = 8'hF1;
                16'h2265: hit.code = 8'hF2;  16'h2264: hit.code = 8'hF3;
                16'h2320: hit.code = 8'hF4;  16'h2321: hit.code = 8'hF5;
                16'h00F7: hit.code = 8'hF6;  16'h2248: hit.code = 8'hF7;
                16'h00B0: hit.code = 8'hF8;  16'h2219: hit.code = 8'hF9;
                16'h00B7: hit.code = 8'hFA;  16'h221A: hit.code = 8'hFB;
                16'h207F: hit.code = 8'hFC;  16'h00B2: hit.code = 8'hFD;
                16'h25A0: hit.code = 8'hFE;  16'h00A0: hit.code = 8'hFF;
                default: begin
                    hit.found = 1'b0;
                    hit.code  = UNDERSCORE;
                end
            endcase
        end
        return hit;
    endfunction

endpackage

FILE: design/utf8_to_cp437_transcoder.sv
// UTF-8 to code page 437 transcoder, top level.
// Depends on u8cp_pkg for word types, register constants and glyph lookup.
//
// Usage:
//   s_valid/s_ready/s_data carry one source byte per word with a last flag.
//   m_valid/m_ready/m_data carry at most one result word per source byte:
//   a converted character, an end-of-string status, or both together.
//   The APB port holds dest_capacity at address 0 (reset 65535); write it
//   only while no string is in flight.
// Timing:
//   A source word goes into an input register, is decoded and looked up
//   combinationally, and lands in the output register, which drives
//   m_valid and m_data. One word is taken every cycle while the output is
//   not stalled; the glyph lookup between the two registers sets the cycle time.
// Reset and stall:
//   aresetn (synchronous, active low) empties both registers, clears the
//   decode state and restores dest_capacity. When m_ready is low with a
//   result waiting, one more word is still taken into the input register;
//   s_ready then drops until the output register frees.
module utf8_to_cp437_transcoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  u8cp_pkg::in_word_t              s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output u8cp_pkg::out_word_t             m_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [u8cp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [u8cp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [u8cp_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import u8cp_pkg::*;

    logic [CAP_W-1:0]   cap_reg, cap_next;
    logic               in_valid_reg, in_valid_next;
    in_word_t           in_data_reg;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_data_reg, out_data_next;
    logic [ACCUM_W-1:0] accum_reg, accum_next;
    logic [2:0]         pending_reg, pending_next;
    logic [CAP_W-1:0]   count_reg, count_next;
    logic               unconv_reg, unconv_next;
    logic               ignore_reg, ignore_next;

    logic               fire, take, res_valid;
    out_word_t          res;
    logic [7:0]         b;
    logic               lst;
    logic               err, complete, unconv_new;
    logic [ACCUM_W-1:0] scalar, accum_shift;
    logic [LEAD_W-1:0]  lead_len;
    logic [2:0]         pending_dec;
    glyph_hit_t         hit;

    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == REG_DEST_CAPACITY) ?
                     APB_DATA_W'(cap_reg) : '0;
    assign cap_next = (psel && penable && pwrite && paddr[2] == REG_DEST_CAPACITY) ?
                      pwdata[CAP_W-1:0] : cap_reg;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign take    = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign b   = in_data_reg.in_byte;
    assign lst = in_data_reg.last;

    always_comb begin
        in_valid_next = take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    end

    // lead byte length
    always_comb begin
        casez (b)
            8'b110?????: lead_len = LEAD_W'(2);
            8'b1110????: lead_len = LEAD_W'(3);
            8'b11110???: lead_len = LEAD_W'(4);
            8'b111110??: lead_len = LEAD_W'(5);
            8'b1111110?: lead_len = LEAD_W'(6);
            default:     lead_len = '0;
        endcase
    end

    assign accum_shift = {accum_reg[ACCUM_W-7:0], b[5:0]};
    assign pending_dec = pending_reg - 3'd1;
    assign hit         = glyph_lookup(scalar);
    assign unconv_new  = unconv_reg || !hit.found;

    always_comb begin
        accum_next   = accum_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        unconv_next  = unconv_reg;
        ignore_next  = ignore_reg;
        res_valid    = 1'b0;
        res          = '0;
        err          = 1'b0;
        complete     = 1'b0;
        scalar       = '0;

        if (pending_reg == 3'd0) begin
            if (b < ASCII_LIMIT) begin
                scalar   = ACCUM_W'(b);
                complete = 1'b1;
            end else if (lead_len == '0 || lead_len > LEAD_W'(MAX_SEQ_BYTES)) begin
                err = 1'b1;
            end
        end else begin
            if (b[7:6] != 2'b10) begin
                err = 1'b1;
            end else if (pending_dec == 3'd0) begin
                scalar   = accum_shift;
                complete = 1'b1;
            end
        end

        if (fire) begin
            if (ignore_reg) begin
                if (b == 8'd0 || lst) begin
                    accum_next   = '0;
                    pending_next = '0;
                    count_next   = '0;
                    unconv_next  = 1'b0;
                    ignore_next  = 1'b0;
                end
            end else if (b == 8'd0) begin
                res_valid         = 1'b1;
                res.done_res      = 1'b1;
                res.utf8_error    = (pending_reg != 3'd0);
                res.unconvertable = (pending_reg == 3'd0) && unconv_reg;
                accum_next        = '0;
                pending_next      = '0;
                count_next        = '0;
                unconv_next       = 1'b0;
            end else if (pending_reg == 3'd0 && count_reg >= cap_reg) begin
                res_valid         = 1'b1;
                res.done_res      = 1'b1;
                res.was_longer    = 1'b1;
                res.unconvertable = unconv_reg;
                accum_next        = '0;
                pending_next      = '0;
                count_next        = '0;
                unconv_next       = 1'b0;
                ignore_next       = !lst;
            end else if (err) begin
                res_valid      = 1'b1;
                res.done_res   = 1'b1;
                res.utf8_error = 1'b1;
                accum_next     = '0;
                pending_next   = '0;
                count_next     = '0;
                unconv_next    = 1'b0;
                ignore_next    = !lst;
            end else if (complete) begin
                res_valid         = 1'b1;
                res.out_byte      = hit.code;
                res.has_byte      = 1'b1;
                res.done_res      = lst;
                res.unconvertable = unconv_new;
                accum_next        = '0;
                pending_next      = '0;
                if (lst) begin
                    count_next  = '0;
                    unconv_next = 1'b0;
                end else begin
                    count_next  = (count_reg < COUNT_MAX) ? count_reg + 1'b1 : count_reg;
                    unconv_next = unconv_new;
                end
            end else if (lst) begin
                res_valid      = 1'b1;
                res.done_res   = 1'b1;
                res.utf8_error = 1'b1;
                accum_next     = '0;
                pending_next   = '0;
                count_next     = '0;
                unconv_next    = 1'b0;
            end else if (pending_reg == 3'd0) begin
                accum_next   = ACCUM_W'(b & (8'h7F >> lead_len));
                pending_next = 3'(lead_len - LEAD_W'(1));
            end else begin
                accum_next   = accum_shift;
                pending_next = pending_dec;
            end
        end
    end

    always_comb begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = res_valid;
            out_data_next  = res;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            accum_reg     <= '0;
            pending_reg   <= '0;
            count_reg     <= '0;
            unconv_reg    <= 1'b0;
            ignore_reg    <= 1'b0;
        end else begin
            cap_reg       <= cap_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            accum_reg     <= accum_next;
            pending_reg   <= pending_next;
            count_reg     <= count_next;
            unconv_reg    <= unconv_next;
            ignore_reg    <= ignore_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_data_reg <= s_data;
        end
        out_data_reg <= out_data_next;
    end

endmodule

FILE: bench/utf8_to_cp437_transcoder_tb.sv
// Self-checking testbench for utf8_to_cp437_transcoder: directed and random UTF-8
// strings, with capacity changes over APB between phases and random stalls on both sides.
// Depends on u8cp_pkg and the transcoder RTL; the expected words come from a local decoder.
module utf8_to_cp437_transcoder_tb;
    import u8cp_pkg::*;

    localparam logic [APB_ADDR_W-1:0] CAP_ADDR   = {REG_DEST_CAPACITY, 2'b00};
    localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {~REG_DEST_CAPACITY, 2'b00};
    localparam int WATCHDOG = 2000;

    localparam logic [16*256-1:0] GLYPH_ROW = {
        16'h0000, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
        16'h25D8, 16'h25E6, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
        16'h25B6, 16'h25C0, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
        16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h2310, 16'h2194, 16'h25B2, 16'h25BC,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
        16'h0040, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A, 16'h005B, 16'h005C, 16'h005D, 16'h005E, 16'h005F,
        16'h0060, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007A, 16'h007B, 16'h007C, 16'h007D, 16'h007E, 16'h007F,
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
        16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
        16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
        16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
        16'h03B1, 16'h03B2, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h03BC, 16'h03C4,
        16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h2205, 16'h2208, 16'h2229,
        16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
        16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
    };

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_word_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_word_t             m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // decoder state
    logic [CAP_W-1:0]   cap_limit    = CAP_RESET;
    logic [ACCUM_W-1:0] scalar_bits  = '0;
    logic [2:0]         conts_left   = '0;
    logic [CAP_W-1:0]   chars_out    = '0;
    bit                 saw_unmapped = 1'b0;
    bit                 skipping     = 1'b0;

    in_word_t  source_words[$];
    out_word_t expected_words[$];
    int        n_queued     = 0;
    int        n_taken      = 0;
    int        errors       = 0;
    int        quiet_cycles = 0;
    bit        in_taken     = 1'b0;
    int        src_odds     = 4;
    int        snk_odds     = 4;
    int        src_gap      = 0;
    int        snk_gap      = 0;

    utf8_to_cp437_transcoder i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [15:0] glyph_at(input int k);
        return GLYPH_ROW[16*(255-k) +: 16];
    endfunction

    function automatic glyph_hit_t cp437_of(input logic [ACCUM_W-1:0] scalar);
        glyph_hit_t hit;
        hit.found = 1'b0;
        hit.code  = UNDERSCORE;
        for (int k = 255; k >= 0; k--) begin
            if ({15'd0, glyph_at(k)} == scalar) begin
                hit.found = 1'b1;
                hit.code  = 8'(k);
            end
        end
        return hit;
    endfunction

    task automatic clear_string();
        scalar_bits  = '0;
        conts_left   = '0;
        chars_out    = '0;
        saw_unmapped = 1'b0;
    endtask

    task automatic transcode_byte(input in_word_t w, output bit emit, output out_word_t r);
        int          ones;
        bit          complete;
        bit          bad;
        logic [ACCUM_W-1:0] scalar;
        glyph_hit_t  hit;
        emit     = 1'b0;
        r        = '0;
        complete = 1'b0;
        bad      = 1'b0;
        scalar   = '0;
        ones     = 0;
        if (skipping) begin
            if (w.in_byte == 8'h00 || w.last) begin
                clear_string();
                skipping = 1'b0;
            end
            return;
        end
        emit = 1'b1;
        r.done_res = 1'b1;
        if (w.in_byte == 8'h00) begin
            if (conts_left != 0) begin
                r.utf8_error = 1'b1;
            end else begin
                r.unconvertable = saw_unmapped;
            end
            clear_string();
            return;
        end
        if (conts_left == 0 && chars_out >= cap_limit) begin
            r.unconvertable = saw_unmapped;
            r.was_longer    = 1'b1;
            clear_string();
            skipping = !w.last;
            return;
        end
        if (conts_left == 0) begin
            if (w.in_byte < ASCII_LIMIT) begin
                scalar   = ACCUM_W'(w.in_byte);
                complete = 1'b1;
            end else begin
                while (ones < 8 && w.in_byte[7-ones]) ones++;
                if (ones < 2 || ones > MAX_SEQ_BYTES) begin
                    bad = 1'b1;
                end else begin
                    scalar_bits = ACCUM_W'(w.in_byte & (8'h7F >> ones));
                    conts_left  = 3'(ones - 1);
                end
            end
        end else if (w.in_byte[7:6] != 2'b10) begin
            bad = 1'b1;
        end else begin
            scalar_bits = {scalar_bits[ACCUM_W-7:0], w.in_byte[5:0]};
            conts_left  = conts_left - 3'd1;
            if (conts_left == 0) begin
                scalar   = scalar_bits;
                complete = 1'b1;
            end
        end
        if (bad) begin
            r.utf8_error = 1'b1;
            clear_string();
            skipping = !w.last;
        end else if (complete) begin
            hit = cp437_of(scalar);
            if (!hit.found) saw_unmapped = 1'b1;
            if (chars_out != COUNT_MAX) chars_out = chars_out + 1'b1;
            scalar_bits     = '0;
            r.out_byte      = hit.code;
            r.has_byte      = 1'b1;
            r.done_res      = w.last;
            r.unconvertable = saw_unmapped;
            if (w.last) clear_string();
        end else if (w.last) begin
            r.utf8_error = 1'b1;
            clear_string();
        end else begin
            emit = 1'b0;
        end
    endtask

    // source side: hold until taken, then advance or idle
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (src_gap > 0) begin
                s_valid <= 1'b0;
                src_gap <= src_gap - 1;
            end else if (src_odds != 0 && $urandom_range(1, src_odds) == 1) begin
                s_valid <= 1'b0;
                src_gap <= $urandom_range(0, 3);
            end else if (source_words.size() != 0) begin
                s_data  <= source_words.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (snk_gap > 0) begin
            m_ready <= 1'b0;
            snk_gap <= snk_gap - 1;
        end else if (snk_odds != 0 && $urandom_range(1, snk_odds) == 1) begin
            m_ready <= 1'b0;
            snk_gap <= $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        bit        emit;
        out_word_t want;
        in_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                transcode_byte(s_data, emit, want);
                if (emit) expected_words.push_back(want);
                n_taken <= n_taken + 1;
            end
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: unexpected word byte=%02h has=%b done=%b unconv=%b longer=%b err=%b",
                             $time, m_data.out_byte, m_data.has_byte, m_data.done_res,
                             m_data.unconvertable, m_data.was_longer, m_data.utf8_error);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    if (m_data !== want) begin
                        $display("%0t: mismatch expected byte=%02h has=%b done=%b unconv=%b longer=%b err=%b",
                                 $time, want.out_byte, want.has_byte, want.done_res,
                                 want.unconvertable, want.was_longer, want.utf8_error);
                        $display("%0t:            actual byte=%02h has=%b done=%b unconv=%b longer=%b err=%b",
                                 $time, m_data.out_byte, m_data.has_byte, m_data.done_res,
                                 m_data.unconvertable, m_data.was_longer, m_data.utf8_error);
                        errors++;
                    end
                end
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG) begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG);
                $display("== FAIL ==");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic reg_write(input logic [APB_ADDR_W-1:0] addr, input logic [CAP_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'($urandom), value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == CAP_ADDR) cap_limit = value;
    endtask

    task automatic reg_check();
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= CAP_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[CAP_W-1:0] !== cap_limit) begin
            $display("%0t: dest_capacity read expected %04h actual %04h",
                     $time, cap_limit, prdata[CAP_W-1:0]);
            errors++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic put(input logic [7:0] b, input bit lst);
        in_word_t w;
        w.in_byte = b;
        w.last    = lst;
        source_words.push_back(w);
        n_queued++;
    endtask

    // first keep bytes of the len-byte form of v
    task automatic put_seq(input logic [30:0] v, input int len, input int keep, input bit lst);
        logic [7:0] b;
        for (int i = 0; i < keep; i++) begin
            if (len == 1)
                b = v[7:0];
            else if (i == 0)
                b = (8'hFF << (8 - len)) | (8'(v >> (6 * (len - 1))) & (8'h7F >> len));
            else
                b = 8'h80 | (8'(v >> (6 * (len - 1 - i))) & 8'h3F);
            put(b, lst && (i == keep - 1));
        end
    endtask

    function automatic int min_len(input logic [30:0] v);
        if (v < 31'h80) return 1;
        if (v < 31'h800) return 2;
        if (v < 31'h10000) return 3;
        if (v < 31'h200000) return 4;
        if (v < 31'h4000000) return 5;
        return 6;
    endfunction

    task automatic put_string();
        int          n_chars;
        int          kind;
        int          len;
        int          m;
        bit          by_last;
        bit          fin;
        logic [30:0] v;
        logic [7:0]  b;
        n_chars = $urandom_range(0, 9);
        by_last = (n_chars != 0) && ($urandom_range(0, 1) == 1);
        for (int c = 0; c < n_chars; c++) begin
            fin  = by_last && (c == n_chars - 1);
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                v   = 31'(glyph_at($urandom_range(1, 255)));
                len = min_len(v);
                if (len < MAX_SEQ_BYTES && $urandom_range(0, 9) == 0) len++;
                put_seq(v, len, len, fin);
            end else if (kind < 72) begin
                put(8'($urandom_range(1, 127)), fin);
            end else if (kind < 88) begin
                len = $urandom_range(2, MAX_SEQ_BYTES);
                v   = 31'($urandom & (32'h7FFFFFFF >> (30 - 5 * len)));
                put_seq(v, len, len, fin);
            end else if (kind < 93) begin
                put(8'($urandom_range(0, 255)), fin);
            end else begin
                // open a sequence, then cut it short
                len = $urandom_range(2, MAX_SEQ_BYTES);
                m   = $urandom_range(0, len - 2);
                v   = 31'($urandom);
                if (kind < 97) begin
                    put_seq(v, len, m + 1, 1'b0);
                    b = 8'($urandom_range(0, 255));
                    if (b[7:6] == 2'b10) b[6] = 1'b1;
                    if ($urandom_range(0, 4) == 0) b = 8'h00;
                    put(b, fin);
                end else begin
                    put_seq(v, len, m + 1, fin);
                end
            end
        end
        if (!by_last) put(8'h00, $urandom_range(0, 1));
    endtask

    task automatic settle();
        do @(negedge aclk); while (n_taken != n_queued || expected_words.size() != 0);
        repeat (6) @(negedge aclk);
    endtask

    initial begin
        int               start;
        logic [CAP_W-1:0] cap_pick;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        reg_check();

        // full capacity: mapped, duplicate glyph, unmapped, six-byte, overlong and bad forms
        put(8'h41, 1'b1);
        put_seq(31'h263A, 3, 3, 1'b0);
        put_seq(31'h2310, 3, 3, 1'b0);
        put_seq(31'h00C7, 2, 2, 1'b0);
        put_seq(31'h4E2D, 3, 3, 1'b0);
        put(8'h00, 1'b0);
        put_seq(31'h7FFFFFFF, 6, 6, 1'b1);
        put(8'hC0, 1'b0); put(8'h80, 1'b0);
        put(8'hFF, 1'b0); put(8'h41, 1'b0); put(8'h00, 1'b0);
        put(8'hFE, 1'b1);
        put(8'hC3, 1'b0); put(8'h41, 1'b0); put(8'h01, 1'b1);
        put(8'hE2, 1'b0); put(8'h98, 1'b1);
        put(8'hF8, 1'b0); put(8'h00, 1'b0);
        put(8'h80, 1'b1);
        settle();

        // capacity zero: cut on the first character
        reg_write(CAP_ADDR, 16'h0000);
        reg_check();
        put(8'h41, 1'b0); put(8'h42, 1'b0); put(8'h00, 1'b1);
        put(8'h00, 1'b0);
        put(8'h43, 1'b1);
        settle();

        // write to the unused slot must leave the capacity alone
        reg_write(SPARE_ADDR, 16'h0005);
        reg_write(CAP_ADDR, 16'h0001);
        reg_check();
        put(8'h78, 1'b0); put(8'h79, 1'b1);
        put(8'h41, 1'b0); put_seq(31'h263A, 3, 3, 1'b0); put(8'h00, 1'b0);
        settle();

        for (int p = 0; p < 7; p++) begin
            case (p)
                0:       cap_pick = CAP_RESET;
                1:       cap_pick = 16'h0000;
                2:       cap_pick = 16'hFFFE;
                3:       cap_pick = 16'($urandom);
                default: cap_pick = 16'($urandom_range(1, 12));
            endcase
            if (p == 6) begin
                src_odds = 0;
                snk_odds = 0;
            end else begin
                src_odds = $urandom_range(2, 8);
                snk_odds = $urandom_range(2, 8);
            end
            reg_write(CAP_ADDR, cap_pick);
            reg_check();
            start = n_queued;
            while (n_queued - start < 150) put_string();
            settle();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
